// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define QRV_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define QRV_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/qrv_pkg.sv -----
// ----------------------------------------------------------------------------
// qrv_pkg
// Word types and derived widths for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qrv_pkg;

  localparam int QUAT_WIDTH = 16;
  localparam int VEC_WIDTH  = 16;

  localparam int QP   = 2 * QUAT_WIDTH;                 // quat square
  localparam int NB   = 2 * QUAT_WIDTH + 1;             // norm, unsigned
  localparam int PV   = QUAT_WIDTH + VEC_WIDTH;         // quat times vec
  localparam int CW   = PV + 1;                         // cross term
  localparam int DW   = PV + 3;                         // doubled dot
  localparam int NW   = 2 * QUAT_WIDTH + VEC_WIDTH + 5; // numerator
  localparam int RW   = NW + 2;                         // divider remainder
  localparam int QB   = VEC_WIDTH + 1;                  // quotient bits
  localparam int DENW = NB + 1;                         // doubled norm

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_x;
    logic signed [QUAT_WIDTH-1:0] quat_y;
    logic signed [QUAT_WIDTH-1:0] quat_z;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
  } quat_word_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        degenerate;
  } rot_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/quaternion_rotate_vector.sv -----
// throughput: one word per cycle while the result side does not stall; the
// result rounding uses a restoring divider with one quotient bit per
// pipeline stage
// a stall on the result side holds every stage in place
// reset (synchronous) clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a vector by a quaternion, normalizing by |q|^2 with rounding and
// saturation; a zero quaternion passes the vector and flags it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quaternion_rotate_vector (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               quat_valid,
  output logic                    quat_ready,
  input  wire qrv_pkg::quat_word_t quat_data,
  output logic                    rot_valid,
  input  wire logic               rot_ready,
  output qrv_pkg::rot_word_t      rot_data
);

  localparam int QW  = qrv_pkg::QUAT_WIDTH;
  localparam int VW  = qrv_pkg::VEC_WIDTH;
  localparam int QB  = qrv_pkg::QB;
  localparam int LAT = 6 + QB;

  logic en;
  logic [LAT:1] vld;

  // side data carried down the whole pipe
  logic signed [VW-1:0] vecp [1:LAT-1][3];
  logic                 deg  [2:LAT-1];

  // stage 1
  logic signed [QW-1:0]      u1 [3];
  logic signed [QW-1:0]      w1;
  logic signed [qrv_pkg::QP-1:0] sq1 [3];
  logic signed [qrv_pkg::QP-1:0] sqw1;
  logic signed [qrv_pkg::PV-1:0] pd1 [3];
  logic signed [qrv_pkg::PV-1:0] cp1 [3];
  logic signed [qrv_pkg::PV-1:0] cn1 [3];

  // stage 2
  logic signed [QW-1:0]          u2 [3];
  logic signed [QW:0]            w2x2;
  logic signed [qrv_pkg::NB:0]   n2;
  logic signed [qrv_pkg::NB:0]   a2;
  logic signed [qrv_pkg::DW-1:0] dot2;
  logic signed [qrv_pkg::CW-1:0] c2 [3];

  // stage 3
  logic [qrv_pkg::NB-1:0]        n3;
  logic signed [qrv_pkg::NW-1:0] ta3 [3];
  logic signed [qrv_pkg::NW-1:0] td3 [3];
  logic signed [qrv_pkg::NW-1:0] tc3 [3];

  // stage 4
  logic [qrv_pkg::NB-1:0] n4;
  logic [qrv_pkg::NW-1:0] mag4 [3];
  logic                   neg4 [3];

  // divider pipe, index 0 is the setup stage
  logic [qrv_pkg::RW-1:0]   drem [0:QB][3];
  logic [QB-1:0]            dq   [0:QB][3];
  logic [qrv_pkg::DENW-1:0] dden [0:QB];
  logic                     dneg [0:QB][3];
  logic                     dovf [0:QB][3];

  assign en         = !vld[LAT] || rot_ready;
  assign quat_ready = en;
  assign rot_valid  = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], quat_valid};
    end
  end

  // stage 1: squares of the quaternion parts and products of its vector part with the vector
  always_ff @(posedge clk) begin
    if (en) begin
      u1[0]      <= quat_data.quat_x;
      u1[1]      <= quat_data.quat_y;
      u1[2]      <= quat_data.quat_z;
      w1         <= quat_data.quat_w;
      vecp[1][0] <= quat_data.vec_x;
      vecp[1][1] <= quat_data.vec_y;
      vecp[1][2] <= quat_data.vec_z;
      sqw1       <= quat_data.quat_w * quat_data.quat_w;
      sq1[0]     <= quat_data.quat_x * quat_data.quat_x;
      sq1[1]     <= quat_data.quat_y * quat_data.quat_y;
      sq1[2]     <= quat_data.quat_z * quat_data.quat_z;
      pd1[0]     <= quat_data.quat_x * quat_data.vec_x;
      pd1[1]     <= quat_data.quat_y * quat_data.vec_y;
      pd1[2]     <= quat_data.quat_z * quat_data.vec_z;
      cp1[0]     <= quat_data.quat_y * quat_data.vec_z;
      cn1[0]     <= quat_data.quat_z * quat_data.vec_y;
      cp1[1]     <= quat_data.quat_z * quat_data.vec_x;
      cn1[1]     <= quat_data.quat_x * quat_data.vec_z;
      cp1[2]     <= quat_data.quat_x * quat_data.vec_y;
      cn1[2]     <= quat_data.quat_y * quat_data.vec_x;
    end
  end

  // stage 2: norm, zero-quaternion check, scalar term, dot and cross products
  always_ff @(posedge clk) begin
    if (en) begin
      n2   <= (qrv_pkg::NB+1)'(sqw1) + (qrv_pkg::NB+1)'(sq1[0])
            + (qrv_pkg::NB+1)'(sq1[1]) + (qrv_pkg::NB+1)'(sq1[2]);
      deg[2] <= (sqw1 == '0) && (sq1[0] == '0) && (sq1[1] == '0) && (sq1[2] == '0);
      a2   <= (qrv_pkg::NB+1)'(sqw1) - (qrv_pkg::NB+1)'(sq1[0])
            - (qrv_pkg::NB+1)'(sq1[1]) - (qrv_pkg::NB+1)'(sq1[2]);
      dot2 <= ((qrv_pkg::DW)'(pd1[0]) + (qrv_pkg::DW)'(pd1[1])
            + (qrv_pkg::DW)'(pd1[2])) <<< 1;
      w2x2 <= (QW+1)'(w1) <<< 1;
      for (int i = 0; i < 3; i++) begin
        u2[i]      <= u1[i];
        c2[i]      <= (qrv_pkg::CW)'(cp1[i]) - (qrv_pkg::CW)'(cn1[i]);
        vecp[2][i] <= vecp[1][i];
      end
    end
  end

  // stage 3: second rank of products
  always_ff @(posedge clk) begin
    if (en) begin
      n3     <= n2[qrv_pkg::NB-1:0];
      deg[3] <= deg[2];
      for (int i = 0; i < 3; i++) begin
        ta3[i]     <= (qrv_pkg::NW)'(a2) * (qrv_pkg::NW)'(vecp[2][i]);
        td3[i]     <= (qrv_pkg::NW)'(dot2) * (qrv_pkg::NW)'(u2[i]);
        tc3[i]     <= (qrv_pkg::NW)'(w2x2) * (qrv_pkg::NW)'(c2[i]);
        vecp[3][i] <= vecp[2][i];
      end
    end
  end

  // stage 4: numerator sum, split into sign and magnitude
  always_ff @(posedge clk) begin
    logic signed [qrv_pkg::NW-1:0] num;
    if (en) begin
      n4     <= n3;
      deg[4] <= deg[3];
      for (int i = 0; i < 3; i++) begin
        num        = ta3[i] + td3[i] + tc3[i];
        neg4[i]    <= num[qrv_pkg::NW-1];
        mag4[i]    <= num[qrv_pkg::NW-1] ? (qrv_pkg::NW)'(-num) : (qrv_pkg::NW)'(num);
        vecp[4][i] <= vecp[3][i];
      end
    end
  end

  // stage 5: rounding offset and overflow check ahead of the divider
  always_ff @(posedge clk) begin
    logic [qrv_pkg::RW-1:0] r0;
    if (en) begin
      dden[0] <= {n4, 1'b0};
      deg[5]  <= deg[4];
      for (int i = 0; i < 3; i++) begin
        r0         = {1'b0, mag4[i], 1'b0} + (qrv_pkg::RW)'(n4);
        drem[0][i] <= r0;
        dovf[0][i] <= r0 >= ((qrv_pkg::RW)'({n4, 1'b0}) << QB);
        dneg[0][i] <= neg4[i];
        dq[0][i]   <= '0;
        vecp[5][i] <= vecp[4][i];
      end
    end
  end

  // divider: one quotient bit per stage, msb first
  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      logic [qrv_pkg::RW-1:0] dsh;
      if (en) begin
        dden[k+1] <= dden[k];
        deg[6+k]  <= deg[5+k];
        dsh = (qrv_pkg::RW)'(dden[k]) << (QB - 1 - k);
        for (int i = 0; i < 3; i++) begin
          if (!dovf[k][i] && (drem[k][i] >= dsh)) begin
            drem[k+1][i] <= drem[k][i] - dsh;
            dq[k+1][i]   <= dq[k][i] | (QB)'(1 << (QB - 1 - k));
          end else begin
            drem[k+1][i] <= drem[k][i];
            dq[k+1][i]   <= dq[k][i];
          end
          dovf[k+1][i]   <= dovf[k][i];
          dneg[k+1][i]   <= dneg[k][i];
          vecp[6+k][i]   <= vecp[5+k][i];
        end
      end
    end
  end

  // output stage: sign, saturation, degenerate bypass
  always_ff @(posedge clk) begin
    logic [VW-1:0] res [3];
    logic          sat;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dneg[QB][i]) begin
          sat = dovf[QB][i] || dq[QB][i][QB-1]
             || (dq[QB][i][VW-1] && (dq[QB][i][VW-2:0] != '0));
          res[i] = sat ? {1'b1, {(VW-1){1'b0}}} : (VW)'(-dq[QB][i][VW-1:0]);
        end else begin
          sat = dovf[QB][i] || (dq[QB][i][QB-1:VW-1] != '0);
          res[i] = sat ? {1'b0, {(VW-1){1'b1}}} : dq[QB][i][VW-1:0];
        end
        if (deg[LAT-1]) begin
          res[i] = vecp[LAT-1][i];
        end
      end
      rot_data.rot_x      <= res[0];
      rot_data.rot_y      <= res[1];
      rot_data.rot_z      <= res[2];
      rot_data.degenerate <= deg[LAT-1];
    end
  end

  `QRV_ASSERT_NXT(a_deg_detect, clk, rst,
    en && vld[1] && (u1[0] == '0) && (u1[1] == '0) && (u1[2] == '0) && (w1 == '0),
    deg[2])
  `QRV_ASSERT_IMP(a_div_rem, clk, rst,
    vld[LAT-1] && !deg[LAT-1] && !dovf[QB][0], drem[QB][0] < (qrv_pkg::RW)'(dden[QB]))
  `QRV_ASSERT_IMP(a_stall_in, clk, rst, rot_valid && !rot_ready, !quat_ready)
  `QRV_ASSERT_NXT(a_hold, clk, rst, rot_valid && !rot_ready, rot_valid && $stable(rot_data))

endmodule

`default_nettype wire
